>>> hw/rtl/orih_pkg.sv
package orih_pkg;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam logic [0:0] REG_START_ADDRESS = 1'b0;

  // Default number of data bytes in one hex line.
  localparam int unsigned LINE_BYTES_DEF = 16;

  // Object record fields.
  localparam logic [7:0]  REC_START_BYTE = 8'h01;
  localparam logic [7:0]  REC_NULL_BYTE  = 8'h00;
  localparam logic [7:0]  REC_TYPE_TEXT  = 8'h03;
  localparam logic [15:0] REC_TEXT_SKIP  = 16'd3;
  localparam logic [15:0] REC_HDR_LEN    = 16'd4;
  localparam logic [15:0] REC_TEXT_OVHD  = 16'd8;
  localparam logic [15:0] REC_END_LEN    = 16'd6;

  // ASCII characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ALPHA = 8'h37;

  typedef enum logic [1:0] {
    ST_TEXT      = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_NULL  = 2'd2,
    ST_END       = 2'd3
  } status_t;

  // Microprogram.
  localparam int unsigned UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_ERR  = 5'd0;
  localparam upc_t UA_LINE = 5'd1;
  localparam upc_t UA_DATA = 5'd10;
  localparam upc_t UA_CSUM = 5'd12;
  localparam upc_t UA_END  = 5'd15;

  typedef enum logic [3:0] {
    SEL_LIT,
    SEL_CNT_HI,
    SEL_CNT_LO,
    SEL_A3,
    SEL_A2,
    SEL_A1,
    SEL_A0,
    SEL_DHI,
    SEL_DLO,
    SEL_SHI,
    SEL_SLO
  } sel_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_STOP,
    J_EMPTY,
    J_MORE,
    J_FIN
  } jmp_t;

  typedef struct packed {
    sel_t       sel;
    logic [7:0] lit;
    jmp_t       jmp;
    upc_t       target;
    logic       init;
    logic       adv;
  } ucw_t;

  typedef struct packed {
    logic    go;
    upc_t    entry;
    logic    fin;
    status_t status;
  } launch_t;

  typedef struct packed {
    logic empty;
    logic more;
    logic fin;
  } cond_t;

  typedef struct packed {
    logic       we;
    logic [7:0] data;
  } wr_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return CH_ZERO + {4'h0, v};
    end
    return CH_ALPHA + {4'h0, v};
  endfunction

  function automatic ucw_t uc(input sel_t s, input logic [7:0] l, input jmp_t j,
                              input upc_t t, input logic i, input logic a);
    return '{s, l, j, t, i, a};
  endfunction

  // One hex line is ':' count address "00" data checksum newline; the end
  // record follows it when the stream finishes.
  function automatic ucw_t ucode(input upc_t pc);
    ucw_t w;
    w = uc(SEL_LIT, CH_NUL, J_STOP, UA_ERR, 1'b0, 1'b0);
    case (pc)
      5'd0:  w = uc(SEL_LIT,    CH_NUL,   J_STOP,  UA_ERR,  1'b0, 1'b0);
      5'd1:  w = uc(SEL_LIT,    CH_COLON, J_NEXT,  UA_ERR,  1'b1, 1'b0);
      5'd2:  w = uc(SEL_CNT_HI, CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd3:  w = uc(SEL_CNT_LO, CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd4:  w = uc(SEL_A3,     CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd5:  w = uc(SEL_A2,     CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd6:  w = uc(SEL_A1,     CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd7:  w = uc(SEL_A0,     CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd8:  w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd9:  w = uc(SEL_LIT,    CH_ZERO,  J_EMPTY, UA_CSUM, 1'b0, 1'b0);
      5'd10: w = uc(SEL_DHI,    CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd11: w = uc(SEL_DLO,    CH_NUL,   J_MORE,  UA_DATA, 1'b0, 1'b0);
      5'd12: w = uc(SEL_SHI,    CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd13: w = uc(SEL_SLO,    CH_NUL,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd14: w = uc(SEL_LIT,    CH_NL,    J_FIN,   UA_END,  1'b0, 1'b1);
      5'd15: w = uc(SEL_LIT,    CH_COLON, J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd16: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd17: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd18: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd19: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd20: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd21: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd22: w = uc(SEL_LIT,    CH_ZERO,  J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd23: w = uc(SEL_LIT,    CH_ONE,   J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd24: w = uc(SEL_LIT,    CH_F,     J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd25: w = uc(SEL_LIT,    CH_F,     J_NEXT,  UA_ERR,  1'b0, 1'b0);
      5'd26: w = uc(SEL_LIT,    CH_NL,    J_STOP,  UA_ERR,  1'b0, 1'b0);
      default: w = uc(SEL_LIT,  CH_NUL,   J_STOP,  UA_ERR,  1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/orih_in_if.sv
interface orih_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/orih_out_if.sv
interface orih_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_char, output out_last, output status, input ready);
  modport sink (input valid, input out_char, input out_last, input status, output ready);
endinterface

>>> hw/rtl/orih_seq.sv
module orih_seq (
  input  logic             clk,
  input  logic             rst,
  input  orih_pkg::launch_t launch,
  input  orih_pkg::cond_t   cond,
  input  logic             out_free,
  output orih_pkg::ucw_t    ctrl,
  output logic             step,
  output logic             busy
);
  import orih_pkg::*;

  upc_t pc;
  logic running;

  assign ctrl = ucode(pc);
  assign step = running && out_free;
  assign busy = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= UA_ERR;
    end else if (launch.go) begin
      running <= 1'b1;
      pc      <= launch.entry;
    end else if (step) begin
      case (ctrl.jmp)
        J_NEXT: begin
          pc <= pc + upc_t'(1);
        end
        J_EMPTY: begin
          pc <= cond.empty ? ctrl.target : pc + upc_t'(1);
        end
        J_MORE: begin
          pc <= cond.more ? ctrl.target : pc + upc_t'(1);
        end
        J_FIN: begin
          if (cond.fin) begin
            pc <= ctrl.target;
          end else begin
            running <= 1'b0;
          end
        end
        default: begin
          running <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/orih_dp.sv
module orih_dp #(
  parameter int unsigned LINE_BYTES = orih_pkg::LINE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  orih_pkg::launch_t                launch,
  input  logic [$clog2(LINE_BYTES+1)-1:0]  cnt_in,
  input  orih_pkg::wr_t                    wr,
  input  logic [((LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1)-1:0] wr_idx,
  input  logic                             cfg_we,
  input  logic [15:0]                      cfg_addr,
  input  logic                             any_data,
  input  orih_pkg::ucw_t                   ctrl,
  input  logic                             step,
  output logic                             out_free,
  output orih_pkg::cond_t                  cond,
  output logic                             advance,
  orih_out_if.source                       res
);
  import orih_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  logic [7:0]       line_mem [LINE_BYTES];
  logic [15:0]      line_addr;
  logic [CNT_W-1:0] cnt;
  logic             fin;
  status_t          stat;
  logic [IDX_W-1:0] idx;
  logic [7:0]       sum;
  logic [7:0]       rd;
  logic [7:0]       cnt8;
  logic [7:0]       csum;
  logic [7:0]       ch;
  logic [7:0]       sum_init;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      line_mem[wr_idx] <= wr.data;
    end
  end

  assign rd       = line_mem[idx];
  assign cnt8     = 8'(cnt);
  assign csum     = 8'h00 - sum;
  assign sum_init = line_addr[15:8] + line_addr[7:0] + cnt8;

  always_comb begin
    case (ctrl.sel)
      SEL_CNT_HI: ch = hex_char(cnt8[7:4]);
      SEL_CNT_LO: ch = hex_char(cnt8[3:0]);
      SEL_A3:     ch = hex_char(line_addr[15:12]);
      SEL_A2:     ch = hex_char(line_addr[11:8]);
      SEL_A1:     ch = hex_char(line_addr[7:4]);
      SEL_A0:     ch = hex_char(line_addr[3:0]);
      SEL_DHI:    ch = hex_char(rd[7:4]);
      SEL_DLO:    ch = hex_char(rd[3:0]);
      SEL_SHI:    ch = hex_char(csum[7:4]);
      SEL_SLO:    ch = hex_char(csum[3:0]);
      default:    ch = ctrl.lit;
    endcase
  end

  assign cond.empty = (cnt == '0);
  assign cond.more  = (CNT_W'(idx) + CNT_W'(1)) != cnt;
  assign cond.fin   = fin;
  assign advance    = step && ctrl.adv && !fin;
  assign out_free   = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_addr <= 16'h0000;
      res.valid <= 1'b0;
    end else begin
      if (cfg_we && !any_data) begin
        line_addr <= cfg_addr;
      end else if (advance) begin
        line_addr <= line_addr + 16'(LINE_BYTES);
      end
      if (step) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch.go) begin
      cnt  <= cnt_in;
      fin  <= launch.fin;
      stat <= launch.status;
    end
    if (step && ctrl.init) begin
      sum <= sum_init;
      idx <= '0;
    end else if (step && ctrl.sel == SEL_DLO) begin
      sum <= sum + rd;
      idx <= idx + IDX_W'(1);
    end
    if (step) begin
      res.out_char <= ch;
      res.out_last <= (ctrl.jmp == J_STOP) || (ctrl.jmp == J_FIN && !fin);
      res.status   <= stat;
    end
  end

endmodule

>>> hw/rtl/orih_parse.sv
module orih_parse #(
  parameter int unsigned LINE_BYTES = orih_pkg::LINE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [7:0]                       in_byte,
  input  logic                             advance,
  output orih_pkg::launch_t                launch,
  output logic [$clog2(LINE_BYTES+1)-1:0]  cnt_out,
  output orih_pkg::wr_t                    wr,
  output logic [((LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1)-1:0] wr_idx,
  output logic                             any_data
);
  import orih_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  typedef enum logic [10:0] {
    PH_START     = 11'b000_0000_0001,
    PH_NULL      = 11'b000_0000_0010,
    PH_LEN_LO    = 11'b000_0000_0100,
    PH_LEN_HI    = 11'b000_0000_1000,
    PH_TYPE      = 11'b000_0001_0000,
    PH_SKIP      = 11'b000_0010_0000,
    PH_DATA      = 11'b000_0100_0000,
    PH_CSUM      = 11'b000_1000_0000,
    PH_ERR_START = 11'b001_0000_0000,
    PH_ERR_NULL  = 11'b010_0000_0000,
    PH_DONE      = 11'b100_0000_0000
  } phase_t;

  phase_t           phase, phase_next;
  logic [15:0]      rec_len, rec_len_next;
  logic [15:0]      bytes_left, bytes_left_next;
  logic             is_text, is_text_next;
  logic             seen_text, seen_text_next;
  logic             ending, ending_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic             any_next;
  logic             do_finish;
  logic             any_data_q;

  assign any_data = any_data_q;

  always_comb begin
    phase_next      = phase;
    rec_len_next    = rec_len;
    bytes_left_next = bytes_left;
    is_text_next    = is_text;
    seen_text_next  = seen_text;
    ending_next     = ending;
    fill_next       = fill;
    any_next        = any_data_q;
    do_finish       = 1'b0;
    launch          = '{go: 1'b0, entry: UA_ERR, fin: 1'b0, status: ST_TEXT};
    cnt_out         = fill;
    wr              = '{we: 1'b0, data: in_byte};
    wr_idx          = fill[IDX_W-1:0];

    if (accept) begin
      case (phase)
        PH_START: begin
          if (in_byte != REC_START_BYTE) begin
            phase_next = PH_ERR_START;
            launch     = '{go: 1'b1, entry: UA_ERR, fin: 1'b0, status: ST_BAD_START};
          end else begin
            phase_next = PH_NULL;
          end
        end
        PH_NULL: begin
          if (in_byte != REC_NULL_BYTE) begin
            phase_next = PH_ERR_NULL;
            launch     = '{go: 1'b1, entry: UA_ERR, fin: 1'b0, status: ST_BAD_NULL};
          end else begin
            phase_next = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          rec_len_next = {8'h00, in_byte};
          phase_next   = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          rec_len_next = {in_byte, rec_len[7:0]};
          phase_next   = PH_TYPE;
        end
        PH_TYPE: begin
          if (in_byte == REC_TYPE_TEXT) begin
            is_text_next    = 1'b1;
            seen_text_next  = 1'b1;
            bytes_left_next = REC_TEXT_SKIP;
            phase_next      = PH_SKIP;
          end else begin
            is_text_next = 1'b0;
            if (seen_text && rec_len == REC_END_LEN) begin
              ending_next = 1'b1;
            end
            if (rec_len > REC_HDR_LEN) begin
              bytes_left_next = rec_len - REC_HDR_LEN;
              phase_next      = PH_SKIP;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_SKIP: begin
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left_next == 16'd0) begin
            if (is_text) begin
              if (rec_len > REC_TEXT_OVHD) begin
                bytes_left_next = rec_len - REC_TEXT_OVHD;
                phase_next      = PH_DATA;
              end else begin
                phase_next = PH_CSUM;
              end
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_DATA: begin
          wr.we     = 1'b1;
          fill_next = fill + CNT_W'(1);
          any_next  = 1'b1;
          if (fill_next >= CNT_W'(LINE_BYTES)) begin
            launch  = '{go: 1'b1, entry: UA_LINE, fin: 1'b0, status: ST_TEXT};
            cnt_out = fill_next;
          end
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left_next == 16'd0) begin
            phase_next = PH_CSUM;
          end
        end
        PH_CSUM: begin
          do_finish = 1'b1;
        end
        PH_ERR_START: begin
          launch = '{go: 1'b1, entry: UA_ERR, fin: 1'b0, status: ST_BAD_START};
        end
        PH_ERR_NULL: begin
          launch = '{go: 1'b1, entry: UA_ERR, fin: 1'b0, status: ST_BAD_NULL};
        end
        PH_DONE: begin
          launch = '{go: 1'b1, entry: UA_ERR, fin: 1'b0, status: ST_END};
        end
        default: begin
          phase_next = PH_START;
        end
      endcase

      if (do_finish) begin
        if (!ending_next) begin
          phase_next = PH_START;
        end else begin
          // The last partial line, or an empty line when no data byte ever
          // came, goes out ahead of the end record.
          phase_next = PH_DONE;
          if (fill != '0) begin
            launch  = '{go: 1'b1, entry: UA_LINE, fin: 1'b1, status: ST_TEXT};
            cnt_out = fill;
          end else if (!any_data_q) begin
            launch  = '{go: 1'b1, entry: UA_LINE, fin: 1'b1, status: ST_TEXT};
            cnt_out = '0;
          end else begin
            launch = '{go: 1'b1, entry: UA_END, fin: 1'b0, status: ST_TEXT};
          end
        end
      end
    end

    if (advance) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      rec_len    <= 16'h0000;
      bytes_left <= 16'h0000;
      is_text    <= 1'b0;
      seen_text  <= 1'b0;
      ending     <= 1'b0;
      fill       <= '0;
      any_data_q <= 1'b0;
    end else begin
      phase      <= phase_next;
      rec_len    <= rec_len_next;
      bytes_left <= bytes_left_next;
      is_text    <= is_text_next;
      seen_text  <= seen_text_next;
      ending     <= ending_next;
      fill       <= fill_next;
      any_data_q <= any_next;
    end
  end

endmodule

>>> hw/rtl/object_records_to_intel_hex.sv
// Object record stream to Intel hex text, one character per cycle unless the output stalls.
// A byte that emits nothing is taken every cycle while no program runs; a byte that
// emits text holds the input until its program, and the end record after a last
// line, is through. The first character is registered from the microword the transfer loads.
// Synchronous reset clears the parser, the sequencer, the output valid, the line address and start_address.
module object_records_to_intel_hex #(
  parameter int unsigned LINE_BYTES = orih_pkg::LINE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [orih_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  orih_in_if.sink                     item,
  orih_out_if.source                  result
);
  import orih_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  logic [15:0]      start_address;
  logic             cfg_we;
  logic             busy;
  logic             accept;
  logic             step;
  logic             out_free;
  logic             advance;
  logic             any_data;
  launch_t          launch;
  cond_t            cond;
  ucw_t             ctrl;
  wr_t              wr;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] wr_idx;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_START_ADDRESS);
  assign prdata = (paddr[APB_AW-1:2] == REG_START_ADDRESS) ? {16'h0000, start_address}
                                                           : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= 16'h0000;
    end else if (cfg_we) begin
      start_address <= pwdata[15:0];
    end
  end

  // Input is held off while the sequencer runs a program.
  assign item.ready = !busy;
  assign accept     = item.valid && !busy;

  orih_parse #(
    .LINE_BYTES(LINE_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (item.in_byte),
    .advance  (advance),
    .launch   (launch),
    .cnt_out  (cnt),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .any_data (any_data)
  );

  orih_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .launch   (launch),
    .cond     (cond),
    .out_free (out_free),
    .ctrl     (ctrl),
    .step     (step),
    .busy     (busy)
  );

  orih_dp #(
    .LINE_BYTES(LINE_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .launch   (launch),
    .cnt_in   (cnt),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .cfg_we   (cfg_we),
    .cfg_addr (pwdata[15:0]),
    .any_data (any_data),
    .ctrl     (ctrl),
    .step     (step),
    .out_free (out_free),
    .cond     (cond),
    .advance  (advance),
    .res      (result)
  );

endmodule
